### src/sekf_pkg.sv
`timescale 1ns / 1ps

package sekf_pkg;

  // field widths
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned RANGE_W = 22;
  localparam int unsigned OUT_W   = 23;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned COV_W   = 32;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned R_W     = 20;

  // config bus
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // shared adder width: 33-bit remainder or partial product plus one
  localparam int unsigned ALU_W = 34;

  // speed of sound 343 m/s, round trip halved afterwards
  localparam logic [8:0] DIST_MUL = 9'd343;
  localparam logic [OUT_W-1:0] INVALID_OFFSET_UM = 23'd1000000;

  // register reset values
  localparam logic [Q_W-1:0]     PROCESS_NOISE_RST = 16'd655;
  localparam logic [R_W-1:0]     MEASURE_NOISE_RST = 20'd6554;
  localparam logic [R_W-1:0]     INIT_COV_RST      = 20'd65536;
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST     = 22'd20000;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST     = 22'd4000000;

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_PROCESS_NOISE = 3'd0,
    REG_MEASURE_NOISE = 3'd1,
    REG_INIT_COV      = 3'd2,
    REG_MIN_RANGE     = 3'd3,
    REG_MAX_RANGE     = 3'd4
  } cfg_reg_e;

endpackage

### src/sonar_echo_kalman_filter.sv
`timescale 1ns / 1ps

// Sonar echo Kalman filter: one echo width in, one filtered range out.
// Input channel: echo_us_i with in_valid_i / in_stall_o. A beat is taken when
// valid is high and stall is low; stall stays high while an item is worked on.
// Output channel: sample_valid_o, raw_range_um_o, filtered_range_um_o,
// gain_q16_o with out_valid_o / out_stall_i, held in an output register.
// Path from the accepting edge to the output register: a rejected echo goes
//   through S_CHECK and S_DONE, a first valid echo through S_CHECK, S_PRED,
//   S_DEN and S_DONE, a filter update also through S_DIV, S_GAIN, S_MUL_X,
//   S_FIX_X, S_MUL_P and S_FIX_P before S_DONE. The sequencer then returns
// to S_IDLE before it takes the next echo. An update is paced by one shared
// 34-bit adder that runs a restoring gain division and two shift-add multiplies,
// FRAC_BITS + 1 steps each.
// A new echo is taken while a finished result waits in the output register;
// if the receiver stalls, the next result waits in its final step until the
// output register frees up.
// Reset clears the filter: estimate 0, gain 0, covariance 1.0 (Q16), not
// primed, and all configuration registers to their defaults. A write to
// initial_covariance is only stored; reset always loads the default.
// Configuration goes through the APB port at byte address 4*index.

module sonar_echo_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sekf_pkg::ECHO_W-1:0]         echo_us_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sample_valid_o,
  output logic [sekf_pkg::OUT_W-1:0]          raw_range_um_o,
  output logic [sekf_pkg::OUT_W-1:0]          filtered_range_um_o,
  output logic [sekf_pkg::GAIN_W-1:0]         gain_q16_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sekf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sekf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sekf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned KW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(KW);
  localparam logic [KW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int unsigned AW = sekf_pkg::ALU_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PRED,
    S_DEN,
    S_DIV,
    S_GAIN,
    S_MUL_X,
    S_FIX_X,
    S_MUL_P,
    S_FIX_P,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [sekf_pkg::Q_W-1:0]     q_noise_q;
  logic [sekf_pkg::R_W-1:0]     r_noise_q;
  logic [sekf_pkg::R_W-1:0]     init_cov_q;
  logic [sekf_pkg::RANGE_W-1:0] min_range_q;
  logic [sekf_pkg::RANGE_W-1:0] max_range_q;

  // filter state
  logic [sekf_pkg::RANGE_W-1:0] x_q;
  logic [sekf_pkg::COV_W-1:0]   cov_q;
  logic [sekf_pkg::GAIN_W-1:0]  gain_q;
  logic                         primed_q;

  // working registers
  logic [sekf_pkg::DIST_W-1:0]  dist_q;
  logic                         echo_nz_q;
  logic                         sv_q;
  logic [sekf_pkg::COV_W-1:0]   p_q;
  logic [sekf_pkg::RANGE_W-1:0] diff_q;
  logic                         up_q;
  logic [KW-1:0]                k_q;
  logic [AW-2:0]                acc_q;
  logic [AW-2:0]                opnd_q;
  logic [KW-1:0]                lo_q;
  logic [CW-1:0]                cnt_q;

  // output register
  logic                         out_valid_q;
  logic                         out_sv_q;
  logic [sekf_pkg::OUT_W-1:0]   out_raw_q;
  logic [sekf_pkg::OUT_W-1:0]   out_filt_q;
  logic [sekf_pkg::GAIN_W-1:0]  out_gain_q;

  // apb write and readback
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q   <= sekf_pkg::PROCESS_NOISE_RST;
      r_noise_q   <= sekf_pkg::MEASURE_NOISE_RST;
      init_cov_q  <= sekf_pkg::INIT_COV_RST;
      min_range_q <= sekf_pkg::MIN_RANGE_RST;
      max_range_q <= sekf_pkg::MAX_RANGE_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        sekf_pkg::REG_PROCESS_NOISE: q_noise_q   <= pwdata[sekf_pkg::Q_W-1:0];
        sekf_pkg::REG_MEASURE_NOISE: r_noise_q   <= pwdata[sekf_pkg::R_W-1:0];
        sekf_pkg::REG_INIT_COV:      init_cov_q  <= pwdata[sekf_pkg::R_W-1:0];
        sekf_pkg::REG_MIN_RANGE:     min_range_q <= pwdata[sekf_pkg::RANGE_W-1:0];
        sekf_pkg::REG_MAX_RANGE:     max_range_q <= pwdata[sekf_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sekf_pkg::REG_PROCESS_NOISE: prdata = 32'(q_noise_q);
      sekf_pkg::REG_MEASURE_NOISE: prdata = 32'(r_noise_q);
      sekf_pkg::REG_INIT_COV:      prdata = 32'(init_cov_q);
      sekf_pkg::REG_MIN_RANGE:     prdata = 32'(min_range_q);
      sekf_pkg::REG_MAX_RANGE:     prdata = 32'(max_range_q);
      default:                     prdata = '0;
    endcase
  end

  // echo width to micrometres
  logic [sekf_pkg::DIST_W:0] echo_prod;
  assign echo_prod = 25'(echo_us_i) * 25'(sekf_pkg::DIST_MUL);

  // range check
  logic dist_ok;
  assign dist_ok = echo_nz_q
                 && (dist_q >= 24'(min_range_q))
                 && (dist_q <= 24'(max_range_q));

  // predicted covariance with saturation
  logic [sekf_pkg::COV_W:0] p_sum;
  assign p_sum = 33'(cov_q) + 33'(q_noise_q);

  // shared adder: subtract in the division, accumulate in the multiplies
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_cin;
  logic [AW:0]   alu_sum;
  logic [AW-1:0] rem2;

  assign rem2 = {acc_q, (cnt_q == '0) ? p_q[0] : 1'b0};

  always_comb begin
    if (state_q == S_DIV) begin
      alu_a   = rem2;
      alu_b   = ~{1'b0, opnd_q};
      alu_cin = 1'b1;
    end else begin
      alu_a   = {1'b0, acc_q};
      alu_b   = lo_q[0] ? {1'b0, opnd_q} : '0;
      alu_cin = 1'b0;
    end
  end

  assign alu_sum = (AW+1)'(alu_a) + (AW+1)'(alu_b) + (AW+1)'(alu_cin);

  // product >> FRAC_BITS, and whether any fraction bit was set
  logic [AW-1:0] prod_sh;
  logic          prod_frac;
  assign prod_sh   = {acc_q, lo_q[KW-1]};
  assign prod_frac = |lo_q[KW-2:0];

  // gain after the zero-denominator and upper clamp
  logic [KW-1:0] k_new;
  assign k_new = ((opnd_q == '0) || (lo_q > ONE)) ? ONE : lo_q;

  logic [sekf_pkg::OUT_W-1:0] bad_range;
  assign bad_range = sekf_pkg::OUT_W'(max_range_q) + sekf_pkg::INVALID_OFFSET_UM;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= '0;
      cov_q       <= 32'(sekf_pkg::INIT_COV_RST);
      gain_q      <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dist_q    <= echo_prod[sekf_pkg::DIST_W:1];
            echo_nz_q <= (echo_us_i != '0);
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          sv_q    <= dist_ok;
          state_q <= dist_ok ? S_PRED : S_DONE;
        end
        S_PRED: begin
          p_q     <= p_sum[sekf_pkg::COV_W] ? '1 : p_sum[sekf_pkg::COV_W-1:0];
          state_q <= S_DEN;
        end
        S_DEN: begin
          if (!primed_q) begin
            x_q      <= dist_q[sekf_pkg::RANGE_W-1:0];
            primed_q <= 1'b1;
            cov_q    <= p_q;
            state_q  <= S_DONE;
          end else begin
            opnd_q  <= 33'(p_q) + 33'(r_noise_q);
            acc_q   <= 33'(p_q >> 1);
            lo_q    <= '0;
            cnt_q   <= '0;
            up_q    <= (dist_q[sekf_pkg::RANGE_W-1:0] >= x_q);
            diff_q  <= (dist_q[sekf_pkg::RANGE_W-1:0] >= x_q)
                       ? dist_q[sekf_pkg::RANGE_W-1:0] - x_q
                       : x_q - dist_q[sekf_pkg::RANGE_W-1:0];
            state_q <= S_DIV;
          end
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          acc_q <= alu_sum[AW] ? alu_sum[AW-2:0] : rem2[AW-2:0];
          lo_q  <= {lo_q[KW-2:0], alu_sum[AW]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(FRAC_BITS)) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          k_q     <= k_new;
          gain_q  <= sekf_pkg::GAIN_W'(k_new);
          acc_q   <= '0;
          lo_q    <= k_new;
          opnd_q  <= 33'(diff_q);
          cnt_q   <= '0;
          state_q <= S_MUL_X;
        end
        // shift-add multiply, one multiplier bit a cycle
        S_MUL_X, S_MUL_P: begin
          acc_q <= alu_sum[AW-1:1];
          lo_q  <= {alu_sum[0], lo_q[KW-1:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(FRAC_BITS)) begin
            state_q <= (state_q == S_MUL_X) ? S_FIX_X : S_FIX_P;
          end
        end
        S_FIX_X: begin
          if (up_q) begin
            x_q <= x_q + prod_sh[sekf_pkg::RANGE_W-1:0];
          end else begin
            x_q <= x_q - prod_sh[sekf_pkg::RANGE_W-1:0]
                 - sekf_pkg::RANGE_W'(prod_frac);
          end
          acc_q   <= '0;
          lo_q    <= ONE - k_q;
          opnd_q  <= 33'(p_q);
          cnt_q   <= '0;
          state_q <= S_MUL_P;
        end
        S_FIX_P: begin
          cov_q   <= prod_sh[sekf_pkg::COV_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sv_q    <= sv_q;
            out_raw_q   <= sv_q ? dist_q[sekf_pkg::OUT_W-1:0] : bad_range;
            out_filt_q  <= sv_q ? sekf_pkg::OUT_W'(x_q) : bad_range;
            out_gain_q  <= gain_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign sample_valid_o      = out_sv_q;
  assign raw_range_um_o      = out_raw_q;
  assign filtered_range_um_o = out_filt_q;
  assign gain_q16_o          = out_gain_q;

  // checks
  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag dropped");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_X || state_q == S_FIX_X || state_q == S_MUL_P) |-> (k_q <= ONE))
    else $error("gain above one");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL_X || state_q == S_MUL_P)
      |-> (cnt_q <= CW'(FRAC_BITS)))
    else $error("step counter overrun");

  a_reject_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |-> (raw_range_um_o == filtered_range_um_o))
    else $error("rejected beat with differing range fields");

endmodule
